// ===== src/atapq_pkg.sv =====
package atapq_pkg;

	// Input command codes
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_IRQ     = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_REG   = 2'd0,
		KIND_XFER  = 2'd1,
		KIND_REPLY = 2'd2
	} kind_t;

	// Reply status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DRIVE  = 2'd1,
		ST_FULL      = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE0 = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE1 = CFG_INDEX_W'(1);

	// Task-file register offsets
	localparam logic [2:0] TF_FEATURES = 3'd1;
	localparam logic [2:0] TF_COUNT    = 3'd2;
	localparam logic [2:0] TF_LBA_LOW  = 3'd3;
	localparam logic [2:0] TF_LBA_MID  = 3'd4;
	localparam logic [2:0] TF_LBA_HIGH = 3'd5;
	localparam logic [2:0] TF_DEVICE   = 3'd6;
	localparam logic [2:0] TF_COMMAND  = 3'd7;

	// Task-file byte values
	localparam logic [7:0] DEV_LBA_BASE  = 8'hE0;
	localparam logic [7:0] ATA_CMD_WRITE = 8'h30;
	localparam logic [7:0] ATA_CMD_READ  = 8'h20;
	localparam logic [3:0] LBA_TOP_MASK  = 4'h0F;

	// Sector geometry
	localparam int SECTOR_BYTES = 512;
	localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
	localparam logic [31:0] SIZE_LIMIT = 32'(255 * SECTOR_BYTES);

	// One queued request
	typedef struct packed {
		logic [31:0] requester;
		logic [31:0] address;
		logic [27:0] sector;
		logic [7:0]  count;
		logic        drive;
		logic        write;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Result source selection
	typedef enum logic [1:0] {
		EMIT_REJECT = 2'd0,
		EMIT_TASK   = 2'd1,
		EMIT_XFER   = 2'd2,
		EMIT_DONE   = 2'd3
	} emit_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       push;
		logic       set_busy;
		logic       clr_busy;
		logic       rd_head;
		logic       load_start;
		logic       emit;
		emit_t      emit_sel;
		logic [2:0] task_offset;
		logic       emit_last;
		logic       pop;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic    command;
		status_t reject;
		logic    busy;
		logic    entry_write;
		logic    remaining_zero;
		logic    remaining_one;
		logic    count_one;
		logic    out_free;
	} dp_status_t;

endpackage

// ===== src/ata_pio_request_queue_sequencer.sv =====
// Queues ATA requests for two drives and runs them one at a time in LBA28 PIO
// mode, emitting task-file writes, sector transfers and replies as results on
// one output register that takes one result per cycle when not stalled. A
// request that starts the drive emits seven or eight results; an interrupt
// emits at most ten. The queue memory has a registered read and needs no
// clearing after reset. Drive sizes must be written only while the block is
// idle; the block itself does not enforce this.
module ata_pio_request_queue_sequencer
	import atapq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [31:0]            requester,
	input  logic [31:0]            buffer_address,
	input  logic                   drive_select,
	input  logic [27:0]            start_sector,
	input  logic [31:0]            byte_size,
	input  logic                   is_write,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             kind,
	output logic [2:0]             reg_offset,
	output logic [7:0]             reg_value,
	output logic [31:0]            transfer_address,
	output logic                   transfer_write,
	output logic [31:0]            reply_requester,
	output logic [1:0]             status,
	output logic                   last
);

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	atapq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	atapq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.command          (command),
		.requester        (requester),
		.buffer_address   (buffer_address),
		.drive_select     (drive_select),
		.start_sector     (start_sector),
		.byte_size        (byte_size),
		.is_write         (is_write),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.reg_offset       (reg_offset),
		.reg_value        (reg_value),
		.transfer_address (transfer_address),
		.transfer_write   (transfer_write),
		.reply_requester  (reply_requester),
		.status           (status),
		.last             (last)
	);

endmodule

// ===== src/atapq_ram.sv =====
module atapq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/atapq_ctrl.sv =====
module atapq_ctrl
	import atapq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_REJECT,
		S_READ,
		S_ENTRY,
		S_TASK,
		S_WXFER,
		S_IRQ,
		S_REPLY
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] task_q, task_d;
	logic       start_q, start_d;

	assign in_stall = (state_q != S_IDLE);

	// Sequence one request or interrupt
	always_comb begin
		state_d = state_q;
		task_d  = task_q;
		start_d = start_q;
		cmd     = '0;
		cmd.task_offset = task_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.command == CMD_REQUEST) begin
					if (sts.reject != ST_OK) begin
						state_d = S_REJECT;
					end else begin
						cmd.push = 1'b1;
						if (sts.busy) begin
							state_d = S_IDLE;
						end else begin
							cmd.set_busy = 1'b1;
							start_d = 1'b1;
							state_d = S_READ;
						end
					end
				end else if (sts.busy) begin
					start_d = 1'b0;
					state_d = S_READ;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_REJECT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_REJECT;
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				cmd.rd_head = 1'b1;
				state_d = S_ENTRY;
			end
			S_ENTRY: begin
				if (start_q) begin
					cmd.load_start = 1'b1;
					task_d = TF_FEATURES;
					state_d = S_TASK;
				end else begin
					state_d = S_IRQ;
				end
			end
			S_TASK: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_TASK;
					cmd.emit_last = (task_q == TF_COMMAND) && !sts.entry_write;
					if (task_q == TF_COMMAND) begin
						state_d = sts.entry_write ? S_WXFER : S_IDLE;
					end else begin
						task_d = task_q + 3'd1;
					end
				end
			end
			S_WXFER: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_XFER;
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_IRQ: begin
				if (sts.entry_write && sts.remaining_zero) begin
					state_d = S_REPLY;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_XFER;
					if (sts.entry_write) begin
						cmd.emit_last = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.emit_last = !sts.remaining_one;
						state_d = sts.remaining_one ? S_REPLY : S_IDLE;
					end
				end
			end
			S_REPLY: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_DONE;
					cmd.emit_last = sts.count_one;
					cmd.pop = 1'b1;
					if (sts.count_one) begin
						cmd.clr_busy = 1'b1;
						state_d = S_IDLE;
					end else begin
						start_d = 1'b1;
						state_d = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			task_q  <= TF_FEATURES;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			task_q  <= task_d;
			start_q <= start_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded while output register is full");

	a_push_only_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (sts.reject == ST_OK) && (sts.command == CMD_REQUEST))
		else $error("rejected request pushed into queue");

	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && in_valid |=> (state_q == S_DECODE))
		else $error("accepted request not decoded");

endmodule

// ===== src/atapq_dp.sv =====
module atapq_dp
	import atapq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             sts,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   command,
	input  logic [31:0]            requester,
	input  logic [31:0]            buffer_address,
	input  logic                   drive_select,
	input  logic [27:0]            start_sector,
	input  logic [31:0]            byte_size,
	input  logic                   is_write,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             kind,
	output logic [2:0]             reg_offset,
	output logic [7:0]             reg_value,
	output logic [31:0]            transfer_address,
	output logic                   transfer_write,
	output logic [31:0]            reply_requester,
	output logic [1:0]             status,
	output logic                   last
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [31:0]      drive0_q, drive1_q;
	logic             in_cmd_q, in_drv_q, in_wr_q;
	logic [31:0]      in_req_q, in_addr_q, in_size_q;
	logic [27:0]      in_sec_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic [31:0]      cur_addr_q;
	logic [7:0]       remaining_q;
	logic             out_valid_q;

	logic [32:0]        size_sum;
	logic [7:0]         new_count;
	status_t            reject;
	entry_t             wr_entry, entry;
	logic [ENTRY_W-1:0] rd_data;
	logic [7:0]         task_value;

	logic [1:0]  res_kind;
	logic [2:0]  res_offset;
	logic [7:0]  res_value;
	logic [31:0] res_addr;
	logic        res_write;
	logic [31:0] res_who;
	logic [1:0]  res_status;

	// Store drive sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive0_q <= '0;
			drive1_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_DRIVE0) begin
				drive0_q <= cfg_data;
			end else if (cfg_index == CFG_DRIVE1) begin
				drive1_q <= cfg_data;
			end
		end
	end

	// Capture the accepted request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_cmd_q  <= command;
			in_req_q  <= requester;
			in_addr_q <= buffer_address;
			in_drv_q  <= drive_select;
			in_sec_q  <= start_sector;
			in_size_q <= byte_size;
			in_wr_q   <= is_write;
		end
	end

	// Round size up to sectors and check for rejection
	assign size_sum  = {1'b0, in_size_q} + 33'(SECTOR_BYTES - 1);
	assign new_count = size_sum[SECTOR_SHIFT +: 8];

	always_comb begin
		if ((in_drv_q ? drive1_q : drive0_q) == 32'd0) begin
			reject = ST_NO_DRIVE;
		end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
			reject = ST_FULL;
		end else if (in_size_q > SIZE_LIMIT) begin
			reject = ST_TOO_LARGE;
		end else begin
			reject = ST_OK;
		end
	end

	assign wr_entry = '{
		requester: in_req_q,
		address:   in_addr_q,
		sector:    in_sec_q,
		count:     new_count,
		drive:     in_drv_q,
		write:     in_wr_q
	};

	atapq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail_q),
		.wdata (wr_entry),
		.re    (cmd.rd_head),
		.raddr (head_q),
		.rdata (rd_data)
	);

	assign entry = entry_t'(rd_data);

	// Advance queue pointers and transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			cur_addr_q  <= '0;
			remaining_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q  <= (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				head_q  <= (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.set_busy) begin
				busy_q <= 1'b1;
			end else if (cmd.clr_busy) begin
				busy_q <= 1'b0;
			end
			if (cmd.load_start) begin
				cur_addr_q  <= entry.address;
				remaining_q <= entry.count;
			end else if (cmd.emit && (cmd.emit_sel == EMIT_XFER)) begin
				cur_addr_q  <= cur_addr_q + 32'(SECTOR_BYTES);
				remaining_q <= remaining_q - 8'd1;
			end
		end
	end

	// Select the task-file byte
	always_comb begin
		case (cmd.task_offset)
			TF_COUNT:    task_value = entry.count;
			TF_LBA_LOW:  task_value = entry.sector[7:0];
			TF_LBA_MID:  task_value = entry.sector[15:8];
			TF_LBA_HIGH: task_value = entry.sector[23:16];
			TF_DEVICE:   task_value = DEV_LBA_BASE | {3'b000, entry.drive, 4'h0}
				| {4'h0, entry.sector[27:24] & LBA_TOP_MASK};
			TF_COMMAND:  task_value = entry.write ? ATA_CMD_WRITE : ATA_CMD_READ;
			default:     task_value = 8'h00;
		endcase
	end

	// Hold output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Build the result payload, zero in every field the kind does not use
	always_comb begin
		res_kind   = KIND_REG;
		res_offset = 3'd0;
		res_value  = 8'h00;
		res_addr   = 32'd0;
		res_write  = 1'b0;
		res_who    = 32'd0;
		res_status = ST_OK;
		case (cmd.emit_sel)
			EMIT_REJECT: begin
				res_kind   = KIND_REPLY;
				res_addr   = in_addr_q;
				res_who    = in_req_q;
				res_status = reject;
			end
			EMIT_TASK: begin
				res_kind   = KIND_REG;
				res_offset = cmd.task_offset;
				res_value  = task_value;
			end
			EMIT_XFER: begin
				res_kind  = KIND_XFER;
				res_addr  = cur_addr_q;
				res_write = entry.write;
			end
			EMIT_DONE: begin
				res_kind = KIND_REPLY;
				res_addr = entry.address;
				res_who  = entry.requester;
			end
			default: begin
				res_kind = KIND_REG;
			end
		endcase
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind             <= res_kind;
			reg_offset       <= res_offset;
			reg_value        <= res_value;
			transfer_address <= res_addr;
			transfer_write   <= res_write;
			reply_requester  <= res_who;
			status           <= res_status;
			last             <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.command        = in_cmd_q;
	assign sts.reject         = reject;
	assign sts.busy           = busy_q;
	assign sts.entry_write    = entry.write;
	assign sts.remaining_zero = (remaining_q == 8'd0);
	assign sts.remaining_one  = (remaining_q == 8'd1);
	assign sts.count_one      = (count_q == CNT_W'(1));
	assign sts.out_free       = !out_valid_q || !out_stall;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (count_q != '0))
		else $error("busy with an empty queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> busy_q && (count_q != '0))
		else $error("pop from an idle queue");

endmodule

// ===== tb/ata_pio_request_queue_sequencer_tb.sv =====
module ata_pio_request_queue_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import atapq_pkg::*;

	localparam int QDEPTH          = 256;
	localparam int MAX_SECTORS     = 255;
	localparam int MAX_PAUSE       = 17;
	localparam int SETTLE_CYCLES   = 24;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int SEGMENT_ITEMS   = 12;
	localparam int FIRST_POWERED   = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_DRIVE1 + 1'b1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = '1;

	// One request as offered on the input side, with an optional typed reply
	typedef struct packed {
		logic        cmd;
		logic [31:0] who;
		logic [31:0] addr;
		logic        drv;
		logic [27:0] lba;
		logic [31:0] size;
		logic        wr;
		logic        typed;
		status_t     want;
	} req_item_t;

	// One bus action of the sequencer: task-file write, sector move or reply
	typedef struct packed {
		kind_t       kind;
		logic [2:0]  offset;
		logic [7:0]  value;
		logic [31:0] address;
		logic        to_disk;
		logic [31:0] target;
		status_t     code;
		logic        closes;
	} result_t;

	// One queued disk request
	typedef struct packed {
		logic [31:0] who;
		logic [31:0] buf_addr;
		logic [27:0] lba;
		logic [7:0]  sectors;
		logic        drv;
		logic        to_disk;
	} pending_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   command;
	logic [31:0]            requester;
	logic [31:0]            buffer_address;
	logic                   drive_select;
	logic [27:0]            start_sector;
	logic [31:0]            byte_size;
	logic                   is_write;
	logic                   out_valid;
	logic                   out_stall;
	logic [1:0]             kind;
	logic [2:0]             reg_offset;
	logic [7:0]             reg_value;
	logic [31:0]            transfer_address;
	logic                   transfer_write;
	logic [31:0]            reply_requester;
	logic [1:0]             status;
	logic                   last;

	// Typed reply that travels with the request on the input side
	logic    typed_check;
	status_t typed_status;

	// Queue and sequencer state as the bus should see it
	pending_t    queued_req [QDEPTH];
	logic [7:0]  q_head = '0;
	logic [7:0]  q_tail = '0;
	int          q_count = 0;
	logic        drive_busy = 1'b0;
	logic [31:0] xfer_addr = '0;
	logic [7:0]  sectors_left = '0;
	logic [31:0] drive_sectors [2] = '{32'd0, 32'd0};

	result_t step_results [$];
	result_t due_results [$];

	int errors = 0;
	int quiet = 0;
	int offered = 0;
	int n_requests = 0;
	int n_refused = 0;
	int n_irqs = 0;
	int n_results = 0;
	int n_settings = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;

	req_item_t directed [15] = '{
		'{CMD_REQUEST, 32'h0000_0000, 32'h0000_0000, 1'b0, 28'h000_0000, 32'h0000_0000,
			1'b0, 1'b1, ST_NO_DRIVE},
		'{CMD_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 28'hFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 1'b1, ST_NO_DRIVE},
		'{CMD_IRQ, 32'h1357_9BDF, 32'h2468_ACE0, 1'b1, 28'h123_4567, 32'h0000_0200,
			1'b1, 1'b0, ST_OK},
		'{CMD_REQUEST, 32'h0000_0031, 32'h0001_0000, 1'b1, 28'h000_0010, 32'd130561,
			1'b0, 1'b1, ST_TOO_LARGE},
		'{CMD_REQUEST, 32'h0000_0042, 32'h0002_0000, 1'b0, 28'h000_0020, 32'hFFFF_FFFF,
			1'b1, 1'b1, ST_TOO_LARGE},
		'{CMD_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FF00, 1'b0, 28'hFFF_FFFF, 32'd1,
			1'b0, 1'b0, ST_OK},
		'{CMD_REQUEST, 32'h0000_0000, 32'hFFFF_FE00, 1'b1, 28'h000_0000, 32'd1024,
			1'b1, 1'b0, ST_OK},
		'{CMD_REQUEST, 32'h8000_0001, 32'h4000_0000, 1'b0, 28'hA5A_5A5A, 32'd130560,
			1'b0, 1'b0, ST_OK},
		'{CMD_IRQ, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, 28'h0F0_F0F0, 32'h1111_1111,
			1'b1, 1'b0, ST_OK},
		'{CMD_IRQ, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b1, 28'hF0F_0F0F, 32'hEEEE_EEEE,
			1'b0, 1'b0, ST_OK},
		'{CMD_IRQ, 32'h7777_7777, 32'h8888_8888, 1'b0, 28'h777_7777, 32'h0000_0001,
			1'b1, 1'b0, ST_OK},
		'{CMD_REQUEST, 32'h5555_5555, 32'hAAAA_AA00, 1'b1, 28'h5A5_A5A5, 32'd0,
			1'b1, 1'b0, ST_OK},
		'{CMD_REQUEST, 32'hAAAA_AAAA, 32'h5555_5400, 1'b0, 28'h0F0_F0F0, 32'd0,
			1'b0, 1'b0, ST_OK},
		'{CMD_REQUEST, 32'h0000_1234, 32'h0000_8000, 1'b0, 28'h000_0200, 32'd512,
			1'b1, 1'b0, ST_OK},
		'{CMD_REQUEST, 32'h0000_5678, 32'h0001_8000, 1'b1, 28'h800_0000, 32'd513,
			1'b0, 1'b0, ST_OK}
	};

	ata_pio_request_queue_sequencer #(.QUEUE_DEPTH(QDEPTH)) uut (.*);

	always #1 clk = ~clk;

	// Append one bus action to the results of the current request
	function automatic void emit_result(kind_t k, logic [2:0] off, logic [7:0] val,
			logic [31:0] addr, logic wr, logic [31:0] who, status_t st);
		step_results.push_back(result_t'{k, off, val, addr, wr, who, st, 1'b0});
	endfunction

	// Move one sector of the head request and count it down
	function automatic void move_one_sector();
		emit_result(KIND_XFER, '0, '0, xfer_addr, queued_req[q_head].to_disk, '0, ST_OK);
		xfer_addr = xfer_addr + 32'(SECTOR_BYTES);
		sectors_left = sectors_left - 8'd1;
	endfunction

	// Load the head request into the task file and issue its command
	function automatic void issue_task_file();
		pending_t e;
		e = queued_req[q_head];
		xfer_addr = e.buf_addr;
		sectors_left = e.sectors;
		emit_result(KIND_REG, TF_FEATURES, 8'h00, '0, 1'b0, '0, ST_OK);
		emit_result(KIND_REG, TF_COUNT, e.sectors, '0, 1'b0, '0, ST_OK);
		emit_result(KIND_REG, TF_LBA_LOW, e.lba[7:0], '0, 1'b0, '0, ST_OK);
		emit_result(KIND_REG, TF_LBA_MID, e.lba[15:8], '0, 1'b0, '0, ST_OK);
		emit_result(KIND_REG, TF_LBA_HIGH, e.lba[23:16], '0, 1'b0, '0, ST_OK);
		emit_result(KIND_REG, TF_DEVICE,
			DEV_LBA_BASE | {3'b000, e.drv, e.lba[27:24] & LBA_TOP_MASK}, '0, 1'b0, '0, ST_OK);
		emit_result(KIND_REG, TF_COMMAND, e.to_disk ? ATA_CMD_WRITE : ATA_CMD_READ,
			'0, 1'b0, '0, ST_OK);
		// a write sends its first sector right behind the command
		if (e.to_disk)
			move_one_sector();
	endfunction

	// Work out the bus actions that one accepted request causes
	function automatic void predict_results(logic cmd, logic [31:0] who, logic [31:0] addr,
			logic drv, logic [27:0] lba, logic [31:0] size, logic wr);
		pending_t    e;
		logic [32:0] need;
		logic        ends;
		status_t     why;
		result_t     tail_res;
		step_results.delete();
		if (cmd == CMD_REQUEST) begin
			n_requests++;
			need = ({1'b0, size} + 33'(SECTOR_BYTES - 1)) >> SECTOR_SHIFT;
			why = ST_OK;
			// refuse in order: absent drive, full queue, oversize
			if (drive_sectors[drv] == 32'd0)
				why = ST_NO_DRIVE;
			else if (q_count >= QDEPTH)
				why = ST_FULL;
			else if (need > 33'(MAX_SECTORS))
				why = ST_TOO_LARGE;
			if (why != ST_OK) begin
				n_refused++;
				emit_result(KIND_REPLY, '0, '0, addr, 1'b0, who, why);
			end else begin
				queued_req[q_tail] = pending_t'{who, addr, lba, need[7:0], drv, wr};
				q_tail = q_tail + 8'd1;
				q_count++;
				if (!drive_busy) begin
					drive_busy = 1'b1;
					issue_task_file();
				end
			end
		end else begin
			n_irqs++;
			// an interrupt with nothing in flight is dropped
			if (drive_busy && q_count != 0) begin
				e = queued_req[q_head];
				if (e.to_disk) begin
					ends = (sectors_left == 8'd0);
					if (!ends)
						move_one_sector();
				end else begin
					move_one_sector();
					ends = (sectors_left == 8'd0);
				end
				if (ends) begin
					emit_result(KIND_REPLY, '0, '0, e.buf_addr, 1'b0, e.who, ST_OK);
					q_head = q_head + 8'd1;
					q_count--;
					if (q_count != 0)
						issue_task_file();
					else
						drive_busy = 1'b0;
				end
			end
		end
		if (step_results.size() != 0) begin
			tail_res = step_results.pop_back();
			tail_res.closes = 1'b1;
			step_results.push_back(tail_res);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Predict on every accepted request, compare every accepted result
	always @(posedge clk) begin : scoreboard
		result_t want;
		bit      moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				if (cfg_index == CFG_DRIVE0)
					drive_sectors[0] = cfg_data;
				else if (cfg_index == CFG_DRIVE1)
					drive_sectors[1] = cfg_data;
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				predict_results(command, requester, buffer_address, drive_select, start_sector,
					byte_size, is_write);
				if (typed_check)
					due_results.push_back(result_t'{KIND_REPLY, 3'd0, 8'd0, buffer_address,
						1'b0, requester, typed_status, 1'b1});
				else
					foreach (step_results[i])
						due_results.push_back(step_results[i]);
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				n_results++;
				if (due_results.size() == 0) begin
					$display("%0t ns: result kind 0x%0h with nothing expected", $time, kind);
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", want.kind, kind);
					check_field("reg_offset", want.offset, reg_offset);
					check_field("reg_value", want.value, reg_value);
					check_field("transfer_address", want.address, transfer_address);
					check_field("transfer_write", want.to_disk, transfer_write);
					check_field("reply_requester", want.target, reply_requester);
					check_field("status", want.code, status);
					check_field("last", want.closes, last);
				end
			end
			quiet = moved ? 0 : quiet + 1;
			if (quiet >= WATCHDOG_CYCLES) begin
				$display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
					$time, quiet, due_results.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Result side: random stall per result, quiet stretches, one long hold-off
	initial begin : receiver
		int pause;
		int served;
		served = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (served % 100 >= 30) begin
				pause = $urandom_range(0, MAX_PAUSE);
				if (pause > 0) begin
					out_stall <= 1'b1;
					repeat (pause) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			served++;
		end
	end

	// Offer one request, hold it until taken, then draw the gap to the next
	task automatic send(input req_item_t r);
		int gap;
		command        <= r.cmd;
		requester      <= r.who;
		buffer_address <= r.addr;
		drive_select   <= r.drv;
		start_sector   <= r.lba;
		byte_size      <= r.size;
		is_write       <= r.wr;
		typed_check    <= r.typed;
		typed_status   <= r.want;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		offered++;
		gap = (offered % 90 < 15) ? 0 : $urandom_range(0, MAX_PAUSE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic req_item_t random_fields();
		req_item_t r;
		r.cmd   = CMD_IRQ;
		r.who   = $urandom;
		r.addr  = $urandom;
		r.drv   = 1'($urandom_range(0, 1));
		r.lba   = 28'($urandom);
		r.size  = $urandom;
		r.wr    = 1'($urandom_range(0, 1));
		r.typed = 1'b0;
		r.want  = ST_OK;
		return r;
	endfunction

	// Wait until every expected result is out, then let the block go idle
	task automatic settle();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Interrupt until the queue is empty
	task automatic drain();
		while (q_count != 0)
			send(random_fields());
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_drives(input logic [31:0] d0, input logic [31:0] d1);
		settle();
		write_reg(CFG_DRIVE0, d0);
		write_reg(CFG_DRIVE1, d1);
		n_settings++;
	endtask

	initial begin : stimulus
		req_item_t r;
		int        pick;
		int        done_cnt;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_DRIVE0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		command        = CMD_REQUEST;
		requester      = '0;
		buffer_address = '0;
		drive_select   = 1'b0;
		start_sector   = '0;
		byte_size      = '0;
		is_write       = 1'b0;
		typed_check    = 1'b0;
		typed_status   = ST_OK;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// random traffic under several drive settings
		for (int seg = 0; seg < 4; seg++) begin
			case (seg)
				0: set_drives($urandom | 32'd1, $urandom | 32'd1);
				1: set_drives(32'd1, 32'd0);
				2: set_drives(32'd0, '1);
				default: set_drives($urandom, 32'h8000_0000);
			endcase
			done_cnt = 0;
			while (done_cnt < SEGMENT_ITEMS) begin
				if (seg == 0 && done_cnt == SEGMENT_ITEMS / 2)
					hold_armed = 1'b1;
				r = random_fields();
				pick = $urandom_range(0, 99);
				if (q_count != 0 ? pick < 55 : pick < 5) begin
					// a stray interrupt on an idle drive does not count
					if (q_count != 0)
						done_cnt++;
				end else begin
					done_cnt++;
					r.cmd = CMD_REQUEST;
					pick = $urandom_range(0, 99);
					if (pick < 65)
						r.size = $urandom_range(1, 2048);
					else if (pick < 80)
						r.size = SECTOR_BYTES * $urandom_range(1, 4);
					else if (pick < 93)
						r.size = $urandom_range(SIZE_LIMIT + 32'd1, 32'hFFFF_FFFF);
					else
						r.size = $urandom_range(1, 16384);
				end
				send(r);
			end
			drain();
		end

		// directed table: first rows run with both drives absent
		set_drives(32'd0, 32'd0);
		for (int i = 0; i < $size(directed); i++) begin
			if (i == FIRST_POWERED) begin
				set_drives('1, 32'd1);
				write_reg(CFG_SPARE_FIRST, 32'h5A5A_5A5A);
				write_reg(CFG_SPARE_LAST, '1);
			end
			send(directed[i]);
		end

		// fill the queue to the brim behind the long transfers, then knock on it
		set_drives(32'd1, 32'd0);
		while (q_count < QDEPTH) begin
			r = random_fields();
			r.cmd  = CMD_REQUEST;
			r.drv  = 1'b0;
			r.size = $urandom_range(1, SECTOR_BYTES);
			send(r);
		end
		for (int i = 0; i < 3; i++) begin
			r = random_fields();
			r.cmd  = CMD_REQUEST;
			r.drv  = (i == 1);
			r.size = (i == 2) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 4096));
			send(r);
		end

		settle();
		$display("Covered %0d new requests (%0d turned away) and %0d interrupts",
			n_requests, n_refused, n_irqs);
		$display("over %0d drive settings, %0d bus actions compared, one %0d-cycle hold-off.",
			n_settings, n_results, HOLD_CYCLES);
		if (errors == 0 && due_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
